### src/drgs_pkg.sv
// ----------------------------------------------------------------------------
// drgs_pkg
// Shared types and constants of the depth to gray range scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package drgs_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned GRAY_BITS       = 8;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [GRAY_BITS-1:0] GRAY_TOP = 8'd255;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_BORDER = 2'd0,
    REG_MAX_BORDER = 2'd1,
    REG_BACK_LEVEL = 2'd2
  } drgs_reg_t;

  // Status of the divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } drgs_div_stat_t;

endpackage

`default_nettype wire

### src/drgs_minmax.sv
// ----------------------------------------------------------------------------
// drgs_minmax
// Running minimum and maximum of the measured samples.
// ----------------------------------------------------------------------------
`default_nettype none

module drgs_minmax #(
  parameter int unsigned SAMPLE_BITS = drgs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   upd,
  input  wire logic                   first,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic      [SAMPLE_BITS-1:0] run_min,
  output logic      [SAMPLE_BITS-1:0] run_max
);
  import drgs_pkg::*;

  logic [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic [SAMPLE_BITS-1:0] max_r, max_nxt;

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (upd) begin
      if (first) begin
        min_nxt = sample;
        max_nxt = sample;
      end else begin
        if (sample < min_r) min_nxt = sample;
        if (sample > max_r) max_nxt = sample;
      end
    end
  end

  // An empty range (min all ones, max zero) makes a convert report an error.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '1;
      max_r <= '0;
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  assign run_min = min_r;
  assign run_max = max_r;

endmodule

`default_nettype wire

### src/drgs_div.sv
// ----------------------------------------------------------------------------
// drgs_div
// Restoring divider, one quotient bit per cycle, for 8-bit quotients.
// ----------------------------------------------------------------------------
`default_nettype none

module drgs_div #(
  parameter int unsigned SAMPLE_BITS = drgs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic [SAMPLE_BITS+drgs_pkg::GRAY_BITS-1:0] num,
  input  wire logic [SAMPLE_BITS:0]                den,
  output drgs_pkg::drgs_div_stat_t                 stat,
  output logic      [drgs_pkg::GRAY_BITS-1:0]      quot,
  output logic      [SAMPLE_BITS:0]                rem
);
  import drgs_pkg::*;

  localparam int unsigned CNT_W = $clog2(GRAY_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GRAY_BITS - 1);

  logic [SAMPLE_BITS:0]   rem_r, rem_nxt;
  logic [GRAY_BITS-1:0]   quot_r, quot_nxt;
  logic [SAMPLE_BITS:0]   den_r, den_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [SAMPLE_BITS+1:0] trial;
  logic [SAMPLE_BITS+1:0] trial_sub;
  logic                   qbit;

  // The caller guarantees num < 256 * den, so the upper part of num is
  // already a valid partial remainder and eight steps finish the job.
  assign trial     = {rem_r, quot_r[GRAY_BITS-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign qbit      = (trial >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, num[SAMPLE_BITS+GRAY_BITS-1:GRAY_BITS]};
      quot_nxt = num[GRAY_BITS-1:0];
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = qbit ? trial_sub[SAMPLE_BITS:0] : trial[SAMPLE_BITS:0];
      quot_nxt = {quot_r[GRAY_BITS-2:0], qbit};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;
  assign rem       = rem_r;

endmodule

`default_nettype wire

### src/depth_to_gray_range_scaler_core.sv
// ----------------------------------------------------------------------------
// depth_to_gray_range_scaler_core
// Min/max contrast stretch of depth samples to 8-bit gray.
// ----------------------------------------------------------------------------
// A measure transaction (tuser bit 0 low) folds its sample into the running
// minimum and maximum and gives no result; tuser bit 1 restarts
// the range at that sample. A convert transaction maps the sample to
// back + (sample - lo) * (255 - back) / (hi - lo + 1), rounded to nearest
// with ties to even and clamped to 0..255, where lo and hi are the measured
// range when both borders are zero and the configured borders otherwise.
// A convert goes from acceptance through setup, two passes through the shared
// multiplier, a check and the eight steps of the restoring divider to the
// output register; skipping the divider, a bad range leaves after the first
// pass and a clamped result after the check. The input is not ready while a
// convert is in progress. The output register lets the next transaction be
// accepted while a result waits to be taken. cfg_ready is always high.
`default_nettype none

module depth_to_gray_range_scaler_core #(
  parameter int unsigned SAMPLE_BITS = drgs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: sample
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]  in_tdata,
  // in_tuser: opcode (bit 0), first (bit 1)
  input  wire logic [1:0]                        in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // out_tdata: gray
  output logic      [drgs_pkg::GRAY_BITS-1:0]    out_tdata,
  // out_tuser: range_error
  output logic      [0:0]                        out_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [drgs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [drgs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import drgs_pkg::*;

  localparam int unsigned SW = SAMPLE_BITS;
  localparam int unsigned DW = SW + 2;   // signed range and offset
  localparam int unsigned MW = DW + 10;  // product of the shared multiplier
  localparam int unsigned NW = SW + 10;  // signed numerator

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL0,
    ST_MUL1,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } st_t;

  st_t                   state_r, state_nxt;
  logic [SW-1:0]         sample_r, sample_nxt;
  logic signed [DW-1:0]  den_r, den_nxt;
  logic signed [DW-1:0]  diff_r, diff_nxt;
  logic signed [NW-1:0]  num_r, num_nxt;
  logic [GRAY_BITS-1:0]  gray_r, gray_nxt;
  logic                  err_r, err_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [GRAY_BITS-1:0]  out_gray_r, out_gray_nxt;
  logic                  out_err_r, out_err_nxt;

  logic [SW-1:0]         min_border_r, max_border_r;
  logic [GRAY_BITS-1:0]  back_r;

  logic                  in_acc;
  logic                  in_op;
  logic [SW-1:0]         in_sample;
  logic [SW-1:0]         run_min, run_max;
  logic [SW-1:0]         lo, hi;

  logic signed [DW-1:0]  mul_a;
  logic signed [9:0]     mul_b;
  logic signed [MW-1:0]  mul_p;

  logic                  div_start;
  drgs_div_stat_t        div_stat;
  logic [GRAY_BITS-1:0]  div_quot;
  logic [SW:0]           div_rem;
  logic [SW+1:0]         two_rem;
  logic                  rnd_up;
  logic [GRAY_BITS-1:0]  rnd_gray;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_op     = in_tuser[0];
  assign in_sample = in_tdata[SW-1:0];
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_border_r <= '0;
      max_border_r <= '0;
      back_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (drgs_reg_t'(cfg_index))
        REG_MIN_BORDER: min_border_r <= SW'(cfg_data);
        REG_MAX_BORDER: max_border_r <= SW'(cfg_data);
        REG_BACK_LEVEL: back_r       <= cfg_data[GRAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  drgs_minmax #(.SAMPLE_BITS(SW)) u_minmax (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (in_acc && (in_op == OP_MEASURE)),
    .first   (in_tuser[1]),
    .sample  (in_sample),
    .run_min (run_min),
    .run_max (run_max)
  );

  always_comb begin
    if ((min_border_r == '0) && (max_border_r == '0)) begin
      lo = run_min;
      hi = run_max;
    end else begin
      lo = min_border_r;
      hi = max_border_r;
    end
  end

  // Shared multiplier: back * den first, then offset * (255 - back).
  always_comb begin
    if (state_r == ST_MUL0) begin
      mul_a = den_r;
      mul_b = $signed({2'b00, back_r});
    end else begin
      mul_a = diff_r;
      mul_b = $signed({2'b00, GRAY_TOP - back_r});
    end
  end
  assign mul_p = mul_a * mul_b;

  assign div_start = (state_r == ST_CHECK) && !num_r[NW-1] &&
                     (num_r[NW-2:0] < {den_r[SW:0], {GRAY_BITS{1'b0}}});

  drgs_div #(.SAMPLE_BITS(SW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r[SW+GRAY_BITS-1:0]),
    .den   (den_r[SW:0]),
    .stat  (div_stat),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // Round to nearest, ties to even, and clamp at the top.
  assign two_rem  = {div_rem, 1'b0};
  assign rnd_up   = (two_rem > {1'b0, den_r[SW:0]}) ||
                    ((two_rem == {1'b0, den_r[SW:0]}) && div_quot[0]);
  assign rnd_gray = (rnd_up && (div_quot != GRAY_TOP)) ? div_quot + 1'b1 : div_quot;

  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    den_nxt       = den_r;
    diff_nxt      = diff_r;
    num_nxt       = num_r;
    gray_nxt      = gray_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_gray_nxt  = out_gray_r;
    out_err_nxt   = out_err_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_op == OP_CONVERT)) begin
          sample_nxt = in_sample;
          state_nxt  = ST_SETUP;
        end
      end
      ST_SETUP: begin
        den_nxt   = $signed({2'b00, hi}) - $signed({2'b00, lo}) + DW'(1);
        diff_nxt  = $signed({2'b00, sample_r}) - $signed({2'b00, lo});
        state_nxt = ST_MUL0;
      end
      ST_MUL0: begin
        if (den_r[DW-1] || (den_r == '0)) begin
          gray_nxt  = '0;
          err_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          num_nxt   = $signed(mul_p[NW-1:0]);
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        num_nxt   = num_r + $signed(mul_p[NW-1:0]);
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        err_nxt = 1'b0;
        if (num_r[NW-1]) begin
          gray_nxt  = '0;
          state_nxt = ST_DONE;
        end else if (!div_start) begin
          gray_nxt  = GRAY_TOP;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          gray_nxt  = rnd_gray;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_gray_nxt  = gray_r;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sample_r   <= sample_nxt;
    den_r      <= den_nxt;
    diff_r     <= diff_nxt;
    num_r      <= num_nxt;
    gray_r     <= gray_nxt;
    err_r      <= err_nxt;
    out_gray_r <= out_gray_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_gray_r;
  assign out_tuser[0] = out_err_r;

endmodule

`default_nettype wire

### src/drgs_checker.sv
// ----------------------------------------------------------------------------
// drgs_checker
// Port-level checks of the depth to gray range scaler, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module drgs_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic [1:0]                       in_tuser,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [drgs_pkg::GRAY_BITS-1:0]   out_tdata,
  input wire logic [0:0]                       out_tuser,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready
);
  import drgs_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A range error always comes with gray zero.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("range error with nonzero gray");

  // The input is not ready in the cycle after a convert transaction is accepted.
  a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == OP_CONVERT) |=> !in_tready)
    else $error("input ready right after a convert");

  // A measure transaction finishes in its own cycle.
  a_meas_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == OP_MEASURE) |=> in_tready)
    else $error("input not ready after a measure");

  // A convert accepted while idle cannot produce a result in the next cycle.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == OP_CONVERT) && !out_tvalid
    |=> !out_tvalid)
    else $error("result appeared too early");

endmodule

bind depth_to_gray_range_scaler_core drgs_checker u_drgs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tuser   (in_tuser),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
